// ----- rtl/random_graph_edge_generator_defines.svh -----
// Assertion macros used by the port-level checker.
`ifndef RANDOM_GRAPH_EDGE_GENERATOR_DEFINES_SVH
`define RANDOM_GRAPH_EDGE_GENERATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RGEG_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RGEG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/rgeg_pkg.sv -----
// Shared types and constants for the random graph edge generator.
package rgeg_pkg;

    localparam int NODE_W = 11;
    localparam int IDX_W  = 10;
    localparam int DEG_W  = 10;
    localparam int WORD_W = 64;
    localparam int M_W    = 54;
    localparam int LOG_W  = 30;
    localparam int SCL_W  = 32;
    localparam int PROD_W = LOG_W + SCL_W;
    localparam int SKIP_W = 22;
    localparam int WQ_W   = 11;
    localparam int CIDX_W = 2;

    localparam logic [DEG_W-1:0] DEG_MAX   = 10'd1023;
    localparam logic [LOG_W-1:0] LOG2_TOP  = 30'd889192448;  // 53 in Q6.24

    localparam logic [CIDX_W-1:0] CFG_NODE_COUNT    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SKIP_SCALE    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_EDGES_ENABLED = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SEED          = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] node_count;
        logic [SCL_W-1:0]  skip_scale;
        logic              edges_enabled;
        logic [WORD_W-1:0] seed;
    } rgeg_cfg_t;

    // queue head toward the engine
    typedef struct packed {
        logic avail;
        logic restart;
    } rgeg_cmd_t;

    // engine status back to the front
    typedef struct packed {
        logic pop;
        logic clearing;
    } rgeg_ctl_t;

endpackage

// ----- rtl/rgeg_front.sv -----
// Front end: input handshake and a two-entry command queue.
module rgeg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                restart,
    input  rgeg_pkg::rgeg_ctl_t ctl,
    output rgeg_pkg::rgeg_cmd_t cmd
);

    logic [1:0] q_reg;
    logic [1:0] q_next;
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign in_ready    = (cnt_reg != 2'd2) && !ctl.clearing;
    assign push        = in_valid && in_ready;
    assign pop         = ctl.pop && (cnt_reg != 2'd0);
    assign cmd.avail   = (cnt_reg != 2'd0);
    assign cmd.restart = q_reg[rp_reg];

    always_comb
    begin
        q_next   = q_reg;
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            q_next[wp_reg] = restart;
            wp_next        = ~wp_reg;
        end
        if (pop)
        begin
            rp_next = ~rp_reg;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ----- rtl/rgeg_log2.sv -----
// Iterative log2 unit: normalize, then 24 squaring steps, Q6.24 result.
module rgeg_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rgeg_pkg::M_W-1:0]      m,
    output logic                          done,
    output logic [rgeg_pkg::LOG_W-1:0]    result
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_SQR  = 4'b0100,
        L_DONE = 4'b1000
    } lstate_t;

    lstate_t                      state_reg;
    lstate_t                      state_next;
    logic [rgeg_pkg::M_W-1:0]     x_reg;
    logic [rgeg_pkg::M_W-1:0]     x_next;
    logic [5:0]                   k_reg;
    logic [5:0]                   k_next;
    logic [31:0]                  y_reg;
    logic [31:0]                  y_next;
    logic [23:0]                  frac_reg;
    logic [23:0]                  frac_next;
    logic [4:0]                   cnt_reg;
    logic [4:0]                   cnt_next;
    logic [63:0]                  sq;
    logic [32:0]                  sh;

    assign sq     = y_reg * y_reg;
    assign sh     = sq[63:31];
    assign done   = (state_reg == L_DONE);
    assign result = {k_reg, frac_reg};

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    x_next     = m;
                    k_next     = 6'd53;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                if (x_reg[53])
                begin
                    y_next     = x_reg[53:22];
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = L_SQR;
                end
                else if (x_reg[53:46] == 8'd0)
                begin
                    x_next = x_reg << 8;
                    k_next = k_reg - 6'd8;
                end
                else
                begin
                    x_next = x_reg << 1;
                    k_next = k_reg - 6'd1;
                end
            end
            L_SQR:
            begin
                frac_next = {frac_reg[22:0], sh[32]};
                y_next    = sh[32] ? sh[32:1] : sh[31:0];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    state_next = L_DONE;
                end
            end
            L_DONE:
            begin
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        k_reg    <= k_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
    end

endmodule

// ----- rtl/rgeg_engine.sv -----
// Back end: random draw, triangle walk, degree store, diagonal scan, output register.
module rgeg_engine #(
    parameter int MAX_NODES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rgeg_pkg::rgeg_cfg_t              cfg,
    input  rgeg_pkg::rgeg_cmd_t              cmd,
    output rgeg_pkg::rgeg_ctl_t              ctl,
    output logic                             log_start,
    output logic [rgeg_pkg::M_W-1:0]         log_m,
    input  logic                             log_done,
    input  logic [rgeg_pkg::LOG_W-1:0]       log_result,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rgeg_pkg::IDX_W-1:0]       row,
    output logic [rgeg_pkg::IDX_W-1:0]       col,
    output logic                             is_diagonal,
    output logic signed [rgeg_pkg::WQ_W-1:0] weight_quarters,
    output logic                             done_res
);

    localparam int AW = $clog2(MAX_NODES);

    typedef enum logic [13:0] {
        E_CLEAR = 14'b00000000000001,
        E_IDLE  = 14'b00000000000010,
        E_RNG   = 14'b00000000000100,
        E_LOG   = 14'b00000000001000,
        E_MUL   = 14'b00000000010000,
        E_SKIP  = 14'b00000000100000,
        E_WALK  = 14'b00000001000000,
        E_RDW   = 14'b00000010000000,
        E_WRW   = 14'b00000100000000,
        E_RDV   = 14'b00001000000000,
        E_WRV   = 14'b00010000000000,
        E_SCAN  = 14'b00100000000000,
        E_CHK   = 14'b01000000000000,
        E_EMIT  = 14'b10000000000000
    } estate_t;

    typedef enum logic [1:0] {
        PH_EDGE = 2'd0,
        PH_DIAG = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        K_EDGE = 2'd0,
        K_DIAG = 2'd1,
        K_DONE = 2'd2
    } kind_t;

    estate_t                             state_reg, state_next;
    phase_t                              phase_reg, phase_next;
    kind_t                               kind_reg, kind_next;
    logic [rgeg_pkg::WORD_W-1:0]         rng_reg, rng_next;
    logic [rgeg_pkg::NODE_W-1:0]         v_reg, v_next;
    logic [rgeg_pkg::NODE_W-1:0]         lp1_reg, lp1_next;
    logic [rgeg_pkg::NODE_W-1:0]         scan_reg, scan_next;
    logic [AW-1:0]                       clr_reg, clr_next;
    logic [rgeg_pkg::LOG_W-1:0]          d_reg, d_next;
    logic [rgeg_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [rgeg_pkg::SKIP_W-1:0]         w_reg, w_next;
    logic [rgeg_pkg::DEG_W-1:0]          deg_reg, deg_next;
    logic                                ov_reg, ov_next;
    logic [rgeg_pkg::IDX_W-1:0]          row_reg, row_next;
    logic [rgeg_pkg::IDX_W-1:0]          col_reg, col_next;
    logic                                diag_reg, diag_next;
    logic signed [rgeg_pkg::WQ_W-1:0]    wq_reg, wq_next;
    logic                                done_reg, done_next;

    logic [rgeg_pkg::DEG_W-1:0]          deg_mem [MAX_NODES];
    logic [rgeg_pkg::DEG_W-1:0]          rdata_reg;
    logic [AW-1:0]                       rd_addr;
    logic                                mem_we;
    logic [AW-1:0]                       mem_wa;
    logic [rgeg_pkg::DEG_W-1:0]          mem_wd;
    logic [rgeg_pkg::DEG_W-1:0]          deg_inc;

    logic [rgeg_pkg::NODE_W-1:0]         n_eff;
    logic [rgeg_pkg::WORD_W-1:0]         xs1, xs2, xs3;
    logic [rgeg_pkg::PROD_W-1:0]         mul;
    logic                                slot_free;
    logic                                pop;

    assign xs1 = rng_reg ^ (rng_reg << 13);
    assign xs2 = xs1 ^ (xs1 >> 7);
    assign xs3 = xs2 ^ (xs2 << 17);
    assign log_m = {1'b0, xs3[63:11]} + {{(rgeg_pkg::M_W-1){1'b0}}, 1'b1};

    assign mul       = d_reg * cfg.skip_scale;
    assign deg_inc   = (rdata_reg == rgeg_pkg::DEG_MAX) ? rdata_reg : rdata_reg + 10'd1;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        if (cfg.node_count < 11'd2)
            n_eff = 11'd2;
        else if (32'(cfg.node_count) > 32'(MAX_NODES))
            n_eff = rgeg_pkg::NODE_W'(MAX_NODES);
        else
            n_eff = cfg.node_count;
    end

    assign ctl.pop      = pop;
    assign ctl.clearing = (state_reg == E_CLEAR);

    assign out_valid       = ov_reg;
    assign row             = row_reg;
    assign col             = col_reg;
    assign is_diagonal     = diag_reg;
    assign weight_quarters = wq_reg;
    assign done_res        = done_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        rng_next   = rng_reg;
        v_next     = v_reg;
        lp1_next   = lp1_reg;
        scan_next  = scan_reg;
        clr_next   = clr_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        w_next     = w_reg;
        deg_next   = deg_reg;
        ov_next    = ov_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        diag_next  = diag_reg;
        wq_next    = wq_reg;
        done_next  = done_reg;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        rd_addr    = '0;
        log_start  = 1'b0;
        pop        = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            E_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = E_IDLE;
                end
            end
            E_IDLE:
            begin
                if (cmd.avail)
                begin
                    pop = 1'b1;
                    if (cmd.restart)
                    begin
                        rng_next   = cfg.seed;
                        v_next     = 11'd1;
                        lp1_next   = '0;
                        phase_next = PH_EDGE;
                        scan_next  = '0;
                        clr_next   = '0;
                        state_next = E_CLEAR;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_EDGE:
                            begin
                                if (cfg.edges_enabled && (v_reg < n_eff))
                                begin
                                    state_next = E_RNG;
                                end
                                else
                                begin
                                    phase_next = PH_DIAG;
                                    state_next = E_SCAN;
                                end
                            end
                            PH_DIAG:
                            begin
                                state_next = E_SCAN;
                            end
                            default:
                            begin
                                kind_next  = K_DONE;
                                state_next = E_EMIT;
                            end
                        endcase
                    end
                end
            end
            E_RNG:
            begin
                rng_next   = xs3;
                log_start  = 1'b1;
                state_next = E_LOG;
            end
            E_LOG:
            begin
                if (log_done)
                begin
                    d_next     = rgeg_pkg::LOG2_TOP - log_result;
                    state_next = E_MUL;
                end
            end
            E_MUL:
            begin
                prod_next  = mul;
                state_next = E_SKIP;
            end
            E_SKIP:
            begin
                w_next     = rgeg_pkg::SKIP_W'(lp1_reg) + prod_reg[61:40];
                state_next = E_WALK;
            end
            E_WALK:
            begin
                if ((w_reg >= rgeg_pkg::SKIP_W'(v_reg)) && (v_reg < n_eff))
                begin
                    w_next = w_reg - rgeg_pkg::SKIP_W'(v_reg);
                    v_next = v_reg + 11'd1;
                end
                else if (v_reg < n_eff)
                begin
                    lp1_next   = w_reg[10:0] + 11'd1;
                    state_next = E_RDW;
                end
                else
                begin
                    phase_next = PH_DIAG;
                    state_next = E_SCAN;
                end
            end
            E_RDW:
            begin
                rd_addr    = AW'(w_reg);
                state_next = E_WRW;
            end
            E_WRW:
            begin
                mem_we     = 1'b1;
                mem_wa     = AW'(w_reg);
                mem_wd     = deg_inc;
                state_next = E_RDV;
            end
            E_RDV:
            begin
                rd_addr    = AW'(v_reg);
                state_next = E_WRV;
            end
            E_WRV:
            begin
                mem_we     = 1'b1;
                mem_wa     = AW'(v_reg);
                mem_wd     = deg_inc;
                kind_next  = K_EDGE;
                state_next = E_EMIT;
            end
            E_SCAN:
            begin
                if (scan_reg < n_eff)
                begin
                    rd_addr    = AW'(scan_reg);
                    state_next = E_CHK;
                end
                else
                begin
                    phase_next = PH_DONE;
                    kind_next  = K_DONE;
                    state_next = E_EMIT;
                end
            end
            E_CHK:
            begin
                scan_next = scan_reg + 11'd1;
                if (rdata_reg != '0)
                begin
                    w_next     = rgeg_pkg::SKIP_W'(scan_reg);
                    deg_next   = rdata_reg;
                    kind_next  = K_DIAG;
                    state_next = E_EMIT;
                end
                else
                begin
                    state_next = E_SCAN;
                end
            end
            E_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    state_next = E_IDLE;
                    case (kind_reg)
                        K_EDGE:
                        begin
                            row_next  = w_reg[9:0];
                            col_next  = v_reg[9:0];
                            diag_next = 1'b0;
                            wq_next   = 11'sd1;
                            done_next = 1'b0;
                        end
                        K_DIAG:
                        begin
                            row_next  = w_reg[9:0];
                            col_next  = w_reg[9:0];
                            diag_next = 1'b1;
                            wq_next   = -$signed({1'b0, deg_reg});
                            done_next = 1'b0;
                        end
                        default:
                        begin
                            row_next  = '0;
                            col_next  = '0;
                            diag_next = 1'b0;
                            wq_next   = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_CLEAR;
            phase_reg <= PH_EDGE;
            kind_reg  <= K_DONE;
            rng_reg   <= 64'd42;
            v_reg     <= 11'd1;
            lp1_reg   <= '0;
            scan_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            rng_reg   <= rng_next;
            v_reg     <= v_next;
            lp1_reg   <= lp1_next;
            scan_reg  <= scan_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        prod_reg <= prod_next;
        w_reg    <= w_next;
        deg_reg  <= deg_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        diag_reg <= diag_next;
        wq_reg   <= wq_next;
        done_reg <= done_next;
    end

    // degree store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            deg_mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= deg_mem[rd_addr];
    end

endmodule

// ----- rtl/random_graph_edge_generator.sv -----
// Top level of the random graph edge generator.
// Streams the edges of a random G(n,p) graph, then one diagonal entry per
// node of nonzero degree, then a done entry repeated on every request.
// Input channel (in_valid/in_ready, restart): restart=1 reseeds the random
// word, restarts the walk and clears the degree store, giving no result;
// restart=0 requests the next entry and gives exactly one result.
// Output channel (out_valid/out_ready): row, col, is_diagonal,
// weight_quarters, done_res. Config port: cfg_we, cfg_index, cfg_data.
// An edge request draws a random word, normalizes the log2 argument, runs 24
// squaring steps of the single 32x32 multiplier, does the scale multiply,
// walks the triangle across the nodes it crosses, and does the read-modify-write
// of both degree counts. A diagonal entry scans the nodes in turn, each by a
// read and a check. One item is worked at a time; a two-entry queue keeps
// taking transactions while the engine is busy.
// After reset and after every restart the degree store is cleared entry by
// entry, and in_ready is low while it clears.
// A stalled receiver holds the output register; the engine waits with its
// next result, and the queue fills, then drops in_ready.
module random_graph_edge_generator #(
    parameter int MAX_NODES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rgeg_pkg::IDX_W-1:0]        row,
    output logic [rgeg_pkg::IDX_W-1:0]        col,
    output logic                              is_diagonal,
    output logic signed [rgeg_pkg::WQ_W-1:0]  weight_quarters,
    output logic                              done_res,
    input  logic                              cfg_we,
    input  logic [rgeg_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [rgeg_pkg::WORD_W-1:0]       cfg_data
);

    rgeg_pkg::rgeg_cfg_t cfg_reg;
    rgeg_pkg::rgeg_cfg_t cfg_next;
    rgeg_pkg::rgeg_cmd_t cmd;
    rgeg_pkg::rgeg_ctl_t ctl;
    logic                             log_start;
    logic [rgeg_pkg::M_W-1:0]         log_m;
    logic                             log_done;
    logic [rgeg_pkg::LOG_W-1:0]       log_result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rgeg_pkg::CFG_NODE_COUNT:    cfg_next.node_count    = cfg_data[10:0];
                rgeg_pkg::CFG_SKIP_SCALE:    cfg_next.skip_scale    = cfg_data[31:0];
                rgeg_pkg::CFG_EDGES_ENABLED: cfg_next.edges_enabled = cfg_data[0];
                rgeg_pkg::CFG_SEED:          cfg_next.seed          = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count    <= 11'd1024;
            cfg_reg.skip_scale    <= 32'd65536;
            cfg_reg.edges_enabled <= 1'b1;
            cfg_reg.seed          <= 64'd42;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rgeg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .ctl      (ctl),
        .cmd      (cmd)
    );

    rgeg_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .m      (log_m),
        .done   (log_done),
        .result (log_result)
    );

    rgeg_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .ctl             (ctl),
        .log_start       (log_start),
        .log_m           (log_m),
        .log_done        (log_done),
        .log_result      (log_result),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row             (row),
        .col             (col),
        .is_diagonal     (is_diagonal),
        .weight_quarters (weight_quarters),
        .done_res        (done_res)
    );

endmodule

// ----- rtl/rgeg_checker.sv -----
// Port-level checker for the random graph edge generator, bound to the top level.
`include "random_graph_edge_generator_defines.svh"

module rgeg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rgeg_pkg::IDX_W-1:0]        row,
    input logic [rgeg_pkg::IDX_W-1:0]        col,
    input logic                              is_diagonal,
    input logic signed [rgeg_pkg::WQ_W-1:0]  weight_quarters,
    input logic                              done_res
);

    `RGEG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output transaction dropped")
    `RGEG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(row) && $stable(col) && $stable(weight_quarters) && $stable(done_res), "stalled payload changed")
    `RGEG_ASSERT_NOW(a_done_zero, !(out_valid && done_res) || (row == '0 && col == '0 && !is_diagonal && weight_quarters == '0), "done entry not zero")
    `RGEG_ASSERT_NOW(a_diag_form, !(out_valid && !done_res && is_diagonal) || (row == col && weight_quarters < 0), "bad diagonal entry")
    `RGEG_ASSERT_NOW(a_edge_form, !(out_valid && !done_res && !is_diagonal) || (weight_quarters == 11'sd1), "bad edge weight")

endmodule

bind random_graph_edge_generator rgeg_checker u_rgeg_checker (.*);
